/* design/vwhd_pkg.sv */
// Shared types and constants of the vertex weld hash table.
`timescale 1ns / 1ps

package vwhd_pkg;

    localparam logic [63:0] FNV_BASIS    = 64'hCBF2_9CE4_8422_2325;
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;
    localparam int          FNV_PRIME_SH = 40;
    localparam logic [31:0] DEFAULT_INV  = 32'd655360000;
    localparam int          ATTR_N       = 8;
    localparam int          WORD_W       = 32;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_REMAP = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_PASS = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_FULL,
        RES_NEW,
        RES_WELD,
        RES_MAP,
        RES_PASS
    } res_sel_t;

    typedef struct packed {
        logic     load;
        logic     hash_step;
        logic     probe_init;
        logic     probe_next;
        logic     insert;
        logic     weld;
        logic     sweep_step;
        logic     clear_cnt;
        logic     res_en;
        res_sel_t res_sel;
        logic     out_load;
    } vwhd_cmd_t;

    typedef struct packed {
        logic hash_done;
        logic vseen_full;
        logic uniq_full;
        logic slot_valid;
        logic key_match;
        logic probe_last;
        logic old_seen;
        logic sweep_last;
        logic out_free;
    } vwhd_sts_t;

endpackage

/* design/vwhd_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module vwhd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/vwhd_ctrl.sv */
// Controller state machine of the vertex weld hash table.
`timescale 1ns / 1ps

module vwhd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic [1:0]         s_tuser,
    output logic               s_tready,
    input  vwhd_pkg::vwhd_sts_t sts,
    output vwhd_pkg::vwhd_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_HASH,
        S_PROBE_RD,
        S_PROBE_CMP,
        S_REMAP,
        S_MAP_WAIT,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   clr_pend_reg, clr_pend_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_SWEEP;
            clr_pend_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_pend_reg <= clr_pend_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd           = '0;
        cmd.res_sel   = vwhd_pkg::RES_ZERO;
        state_next    = state_reg;
        clr_pend_next = clr_pend_reg;
        case (state_reg)
            S_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last) begin
                    state_next    = clr_pend_reg ? S_RESULT : S_IDLE;
                    clr_pend_next = 1'b0;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    case (vwhd_pkg::kind_t'(s_tuser))
                        vwhd_pkg::KIND_ADD:   state_next = S_HASH;
                        vwhd_pkg::KIND_REMAP: state_next = S_REMAP;
                        vwhd_pkg::KIND_CLEAR: begin
                            cmd.clear_cnt = 1'b1;
                            cmd.res_en    = 1'b1;
                            clr_pend_next = 1'b1;
                            state_next    = S_SWEEP;
                        end
                        default: begin
                            cmd.res_en = 1'b1;
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_HASH: begin
                cmd.hash_step = 1'b1;
                if (sts.hash_done) begin
                    if (sts.vseen_full) begin
                        cmd.res_en  = 1'b1;
                        cmd.res_sel = vwhd_pkg::RES_FULL;
                        state_next  = S_RESULT;
                    end else begin
                        cmd.probe_init = 1'b1;
                        state_next     = S_PROBE_RD;
                    end
                end
            end
            S_PROBE_RD: begin
                state_next = S_PROBE_CMP;
            end
            S_PROBE_CMP: begin
                if (!sts.slot_valid) begin
                    cmd.res_en = 1'b1;
                    if (sts.uniq_full) begin
                        cmd.res_sel = vwhd_pkg::RES_FULL;
                    end else begin
                        cmd.insert  = 1'b1;
                        cmd.res_sel = vwhd_pkg::RES_NEW;
                    end
                    state_next = S_RESULT;
                end else if (sts.key_match) begin
                    cmd.weld    = 1'b1;
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = vwhd_pkg::RES_WELD;
                    state_next  = S_RESULT;
                end else if (sts.probe_last) begin
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = vwhd_pkg::RES_FULL;
                    state_next  = S_RESULT;
                end else begin
                    cmd.probe_next = 1'b1;
                    state_next     = S_PROBE_RD;
                end
            end
            S_REMAP: begin
                if (sts.old_seen) begin
                    state_next = S_MAP_WAIT;
                end else begin
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = vwhd_pkg::RES_PASS;
                    state_next  = S_RESULT;
                end
            end
            S_MAP_WAIT: begin
                cmd.res_en  = 1'b1;
                cmd.res_sel = vwhd_pkg::RES_MAP;
                state_next  = S_RESULT;
            end
            S_RESULT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_SWEEP;
            end
        endcase
    end

endmodule

/* design/vwhd_dp.sv */
// Datapath of the vertex weld hash table: quantizer, hash, probe and stores.
`timescale 1ns / 1ps

module vwhd_dp #(
    parameter int MAX_VERTICES = 4096,
    parameter int TABLE_SLOTS  = 8192
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wen,
    input  logic [31:0]         cfg_wdata,
    input  logic [287:0]        s_tdata,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [47:0]         m_tdata,
    input  vwhd_pkg::vwhd_cmd_t cmd,
    output vwhd_pkg::vwhd_sts_t sts
);

    localparam int IDXW  = $clog2(MAX_VERTICES);
    localparam int CNTW  = $clog2(MAX_VERTICES + 1);
    localparam int SLOTW = $clog2(TABLE_SLOTS);
    localparam int KEYW  = vwhd_pkg::ATTR_N * vwhd_pkg::WORD_W;

    logic [31:0]      inv_reg;
    logic [31:0]      attr_reg [vwhd_pkg::ATTR_N];
    logic [31:0]      old_reg;
    logic [3:0]       word_cnt_reg;
    logic [3:0]       fold_cnt_reg;
    logic [63:0]      prod_reg;
    logic             neg_reg;
    logic             prod_vld_reg;
    logic [63:0]      hash_reg;
    logic [31:0]      key_reg [vwhd_pkg::ATTR_N];
    logic [SLOTW-1:0] slot_reg;
    logic [SLOTW-1:0] probe_cnt_reg;
    logic [SLOTW-1:0] sweep_addr_reg;
    logic [CNTW-1:0]  vseen_reg;
    logic [CNTW-1:0]  uniq_reg;
    logic [CNTW-1:0]  welds_reg;
    logic [31:0]      res_index_reg;
    logic             res_merged_reg;
    logic [1:0]       res_status_reg;
    logic             m_tvalid_reg;
    logic [47:0]      m_tdata_reg;

    logic [31:0]      scale;
    logic [31:0]      mag;
    logic [63:0]      rnd;
    logic [31:0]      q;
    logic [31:0]      qword;
    logic [63:0]      fold_x;
    logic [63:0]      hash_next;
    logic [KEYW-1:0]  key_flat;
    logic [KEYW+IDXW-1:0] krd_data;
    logic             vrd_data;
    logic [IDXW-1:0]  mrd_data;
    logic             vwr_en;
    logic [SLOTW-1:0] vwr_addr;
    logic [IDXW-1:0]  map_wdata;

    assign scale = (inv_reg == '0) ? vwhd_pkg::DEFAULT_INV : inv_reg;
    assign mag   = attr_reg[0][31] ? (~attr_reg[0] + 32'd1) : attr_reg[0];
    assign rnd   = prod_reg + 64'h0000_0000_8000_0000;
    assign q     = rnd[63:32];

    always_comb begin
        if (neg_reg) begin
            qword = (q > 32'h8000_0000) ? 32'h8000_0000 : (~q + 32'd1);
        end else begin
            qword = (q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
        end
        fold_x    = hash_reg ^ {{32{qword[31]}}, qword};
        hash_next = (fold_x << vwhd_pkg::FNV_PRIME_SH)
                  + (fold_x * {55'd0, vwhd_pkg::FNV_PRIME_LO});
        for (int i = 0; i < vwhd_pkg::ATTR_N; i++) begin
            key_flat[i*32 +: 32] = key_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_reg <= vwhd_pkg::DEFAULT_INV;
        end else if (cfg_wen) begin
            inv_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < vwhd_pkg::ATTR_N; i++) begin
                attr_reg[i] <= s_tdata[i*32 +: 32];
            end
            old_reg  <= s_tdata[287:256];
            hash_reg <= vwhd_pkg::FNV_BASIS;
        end else if (cmd.hash_step) begin
            if (word_cnt_reg != 4'd8) begin
                prod_reg <= mag * scale;
                neg_reg  <= attr_reg[0][31];
                for (int i = 0; i < vwhd_pkg::ATTR_N - 1; i++) begin
                    attr_reg[i] <= attr_reg[i+1];
                end
            end
            if (prod_vld_reg) begin
                hash_reg <= hash_next;
                for (int i = 0; i < vwhd_pkg::ATTR_N - 1; i++) begin
                    key_reg[i] <= key_reg[i+1];
                end
                key_reg[vwhd_pkg::ATTR_N-1] <= qword;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_cnt_reg   <= '0;
            fold_cnt_reg   <= '0;
            prod_vld_reg   <= 1'b0;
            sweep_addr_reg <= '0;
            vseen_reg      <= '0;
            uniq_reg       <= '0;
            welds_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cmd.load) begin
                word_cnt_reg <= '0;
                fold_cnt_reg <= '0;
                prod_vld_reg <= 1'b0;
            end else if (cmd.hash_step) begin
                prod_vld_reg <= (word_cnt_reg != 4'd8);
                if (word_cnt_reg != 4'd8) begin
                    word_cnt_reg <= word_cnt_reg + 4'd1;
                end
                if (prod_vld_reg) begin
                    fold_cnt_reg <= fold_cnt_reg + 4'd1;
                end
            end
            if (cmd.sweep_step) begin
                sweep_addr_reg <= sweep_addr_reg + 1'b1;
            end
            if (cmd.clear_cnt) begin
                vseen_reg <= '0;
                uniq_reg  <= '0;
                welds_reg <= '0;
            end else if (cmd.insert) begin
                vseen_reg <= vseen_reg + 1'b1;
                uniq_reg  <= uniq_reg + 1'b1;
            end else if (cmd.weld) begin
                vseen_reg <= vseen_reg + 1'b1;
                welds_reg <= welds_reg + 1'b1;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.probe_init) begin
            slot_reg      <= hash_reg[SLOTW-1:0];
            probe_cnt_reg <= '0;
        end else if (cmd.probe_next) begin
            slot_reg      <= slot_reg + 1'b1;
            probe_cnt_reg <= probe_cnt_reg + 1'b1;
        end
        if (cmd.res_en) begin
            case (cmd.res_sel)
                vwhd_pkg::RES_FULL: begin
                    res_index_reg  <= '0;
                    res_merged_reg <= 1'b0;
                    res_status_reg <= vwhd_pkg::STATUS_FULL;
                end
                vwhd_pkg::RES_NEW: begin
                    res_index_reg  <= 32'(uniq_reg);
                    res_merged_reg <= 1'b0;
                    res_status_reg <= vwhd_pkg::STATUS_OK;
                end
                vwhd_pkg::RES_WELD: begin
                    res_index_reg  <= 32'(krd_data[KEYW +: IDXW]);
                    res_merged_reg <= 1'b1;
                    res_status_reg <= vwhd_pkg::STATUS_OK;
                end
                vwhd_pkg::RES_MAP: begin
                    res_index_reg  <= 32'(mrd_data);
                    res_merged_reg <= 1'b0;
                    res_status_reg <= vwhd_pkg::STATUS_OK;
                end
                vwhd_pkg::RES_PASS: begin
                    res_index_reg  <= old_reg;
                    res_merged_reg <= 1'b0;
                    res_status_reg <= vwhd_pkg::STATUS_PASS;
                end
                default: begin
                    res_index_reg  <= '0;
                    res_merged_reg <= 1'b0;
                    res_status_reg <= vwhd_pkg::STATUS_OK;
                end
            endcase
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {13'(welds_reg), res_status_reg, res_merged_reg, res_index_reg};
        end
    end

    assign vwr_en    = cmd.sweep_step | cmd.insert;
    assign vwr_addr  = cmd.sweep_step ? sweep_addr_reg : slot_reg;
    assign map_wdata = cmd.insert ? uniq_reg[IDXW-1:0] : krd_data[KEYW +: IDXW];

    vwhd_ram #(.WIDTH(1), .DEPTH(TABLE_SLOTS)) u_valid_ram (
        .aclk    (aclk),
        .wr_en   (vwr_en),
        .wr_addr (vwr_addr),
        .wr_data (cmd.insert),
        .rd_addr (slot_reg),
        .rd_data (vrd_data)
    );

    vwhd_ram #(.WIDTH(KEYW + IDXW), .DEPTH(TABLE_SLOTS)) u_key_ram (
        .aclk    (aclk),
        .wr_en   (cmd.insert),
        .wr_addr (slot_reg),
        .wr_data ({uniq_reg[IDXW-1:0], key_flat}),
        .rd_addr (slot_reg),
        .rd_data (krd_data)
    );

    vwhd_ram #(.WIDTH(IDXW), .DEPTH(MAX_VERTICES)) u_map_ram (
        .aclk    (aclk),
        .wr_en   (cmd.insert | cmd.weld),
        .wr_addr (vseen_reg[IDXW-1:0]),
        .wr_data (map_wdata),
        .rd_addr (old_reg[IDXW-1:0]),
        .rd_data (mrd_data)
    );

    assign sts.hash_done  = (fold_cnt_reg == 4'd8);
    assign sts.vseen_full = (vseen_reg == CNTW'(MAX_VERTICES));
    assign sts.uniq_full  = (uniq_reg == CNTW'(MAX_VERTICES));
    assign sts.slot_valid = vrd_data;
    assign sts.key_match  = (krd_data[KEYW-1:0] == key_flat);
    assign sts.probe_last = (probe_cnt_reg == SLOTW'(TABLE_SLOTS - 1));
    assign sts.old_seen   = (old_reg < 32'(vseen_reg));
    assign sts.sweep_last = (sweep_addr_reg == SLOTW'(TABLE_SLOTS - 1));
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* design/vertex_weld_hash_dedup.sv */
// Top level of the vertex weld hash table.
`timescale 1ns / 1ps

// Welds vertices by quantized key through a linear-probe hash table; one result word
// per input word. After reset and after each clear word the table runs a clearing
// pass over all TABLE_SLOTS slots during which no input word is taken. An add word
// steps eight times through the shared quantizing multiplier and hash fold, then
// makes one registered table read per probe (no probe when the vertex map is already
// full); a remap word reads the vertex map only for an index already seen. A stalled
// result holds off the next word. TABLE_SLOTS must be a power of two.
module vertex_weld_hash_dedup #(
    parameter int MAX_VERTICES = 4096,
    parameter int TABLE_SLOTS  = 8192
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wen,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tex_u, tex_v, old_index
    input  logic [287:0] s_tdata,
    // kind
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // index_out, merged, status, welded_count
    output logic [47:0]  m_tdata
);

    vwhd_pkg::vwhd_cmd_t cmd;
    vwhd_pkg::vwhd_sts_t sts;

    vwhd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vwhd_dp #(.MAX_VERTICES(MAX_VERTICES), .TABLE_SLOTS(TABLE_SLOTS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

/* design/vwhd_checker.sv */
// Port checker of the vertex weld hash table and its bind.
`timescale 1ns / 1ps

module vwhd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Result word changed while stalled.");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Result word valid right after reset.");

    a_merged_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> m_tdata[34:33] == vwhd_pkg::STATUS_OK)
        else $error("Welded vertex reported with a non-ok status.");

    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[34:33] == vwhd_pkg::STATUS_FULL
            |-> m_tdata[31:0] == 32'd0 && !m_tdata[32])
        else $error("Dropped vertex reported an index or a weld.");

endmodule

bind vertex_weld_hash_dedup vwhd_checker u_vwhd_checker (.*);
